[sv/bzmtf_pkg.sv]
// ============================================================================
// bzmtf_pkg
// Shared constants, result codes and controller states for the bzip2
// move-to-front and zero-run decoder.
// ============================================================================
`default_nettype none

package bzmtf_pkg;

  localparam int LIST_DEPTH     = 256;
  localparam int LIST_AW        = 8;
  localparam int MAX_RUN_DIGITS = 21;
  localparam int SYM_W          = 9;
  localparam int USED_W         = 9;
  localparam int CNT_W          = 20;
  localparam int SUM_W          = 22;
  localparam int POS_W          = 5;
  localparam int KIND_W         = 3;
  localparam int BYTE_W         = 8;
  localparam int CFG_AW         = 6;
  localparam int CFG_DW         = 64;

  localparam logic [CNT_W-1:0] BLOCK_MAX = 20'd900000;

  localparam logic [2:0] REG_BM0   = 3'd0;
  localparam logic [2:0] REG_BM1   = 3'd1;
  localparam logic [2:0] REG_BM2   = 3'd2;
  localparam logic [2:0] REG_BM3   = 3'd3;
  localparam logic [2:0] REG_LIMIT = 3'd4;

  localparam logic [KIND_W-1:0] KIND_DATA = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EOB  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LONG = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OVF  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BAD  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RUN_RD,
    ST_RUN_SL,
    ST_RUN_EM,
    ST_NEXT,
    ST_REG_RD,
    ST_REG_SL,
    ST_SHIFT,
    ST_FRONT,
    ST_ERR
  } state_t;

endpackage

`default_nettype wire

[sv/bzmtf_ram.sv]
// ============================================================================
// bzmtf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module bzmtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/bzip2_mtf_run_decoder_core.sv]
// ============================================================================
// bzip2_mtf_run_decoder_core
// Move-to-front list and RUNA/RUNB zero-run decoder for bzip2 symbols.
// ============================================================================
//  channel  ports                                 direction
//  in       in_valid/in_ready, in_symbol          request in
//  out      out_valid/out_ready, out_kind/value/  request out
//           out_count/out_last
//  cfg      psel/penable/pwrite/paddr/pwdata/     APB write/read, 64-bit data
//           prdata/pready
//
//  A run digit adds to the run sum; a run close looks up the front byte.
//  For a regular symbol at list position p, one list entry is moved per cycle
//  through the front-list RAM read/write ports.
//  Each bitmap write starts a slot table rebuild; no input meanwhile.
//  Reset is synchronous; list reset is held in 256 valid flops, cleared at once.
//  An output register lets the next input be taken while a result waits.
// ============================================================================
`default_nettype none

module bzip2_mtf_run_decoder_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bzmtf_pkg::SYM_W-1:0]    in_symbol,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [bzmtf_pkg::KIND_W-1:0]   out_kind,
  output logic      [bzmtf_pkg::BYTE_W-1:0]   out_value,
  output logic      [bzmtf_pkg::CNT_W-1:0]    out_count,
  output logic                                out_last,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bzmtf_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [bzmtf_pkg::CFG_DW-1:0]   pwdata,
  output logic      [bzmtf_pkg::CFG_DW-1:0]   prdata,
  output logic                                pready
);
  import bzmtf_pkg::*;

  // configuration
  logic [3:0][CFG_DW-1:0] bm_r;
  logic [CNT_W-1:0]       lim_r;
  logic [2:0]             cidx;
  logic                   cwr;
  logic                   reb_r;
  logic [LIST_AW-1:0]     v_r;
  logic [USED_W-1:0]      k_r;
  logic [USED_W-1:0]      used_r;
  logic                   bm_bit;

  // block state
  state_t                 st_r, st_nxt;
  logic [LIST_AW-1:0]     p_r, p_nxt;
  logic                   eob_r, eob_nxt;
  logic [KIND_W-1:0]      ek_r, ek_nxt;
  logic [BYTE_W-1:0]      e_r, e_nxt;
  logic [BYTE_W-1:0]      byte_r, byte_nxt;
  logic [LIST_AW-1:0]     j_r, j_nxt;
  logic                   ract_r, ract_nxt;
  logic [SUM_W-1:0]       rsum_r, rsum_nxt;
  logic [POS_W-1:0]       rpos_r, rpos_nxt;
  logic [CNT_W-1:0]       bytes_r, bytes_nxt;
  logic [LIST_DEPTH-1:0]  vld_r, vld_nxt;
  logic                   clr;

  // memories
  logic                   fre, fwe, sre, swe;
  logic [LIST_AW-1:0]     fra, fwa, sra, swa;
  logic [BYTE_W-1:0]      fwd, fq, sq, swd;
  logic [LIST_AW-1:0]     fa_q, sa_q;
  logic [BYTE_W-1:0]      fv, sv;

  // output
  logic                   ov_r;
  logic [KIND_W-1:0]      ok_r;
  logic [BYTE_W-1:0]      oval_r;
  logic [CNT_W-1:0]       ocnt_r;
  logic                   olast_r;
  logic                   ld, ld_last, out_free;
  logic [KIND_W-1:0]      ld_kind;
  logic [BYTE_W-1:0]      ld_val;
  logic [CNT_W-1:0]       ld_cnt;

  // classification
  logic [USED_W:0]        eob_sym;
  logic                   is_eob, is_bad, is_dig, acc;
  logic [CNT_W-1:0]       lim;
  logic [SUM_W:0]         run_tot;
  logic                   ovf_run, ovf_byte;
  logic [SUM_W-1:0]       dig_val;

  bzmtf_ram #(.WIDTH(BYTE_W), .DEPTH(LIST_DEPTH)) u_front (
    .clk(clk), .we(fwe), .waddr(fwa), .wdata(fwd),
    .re(fre), .raddr(fra), .rdata(fq)
  );

  bzmtf_ram #(.WIDTH(BYTE_W), .DEPTH(LIST_DEPTH)) u_slot (
    .clk(clk), .we(swe), .waddr(swa), .wdata(swd),
    .re(sre), .raddr(sra), .rdata(sq)
  );

  assign cidx   = paddr[5:3];
  assign cwr    = psel & penable & pwrite;
  assign pready = 1'b1;
  assign bm_bit = bm_r[v_r[7:6]][v_r[5:0]];
  assign swe    = reb_r & bm_bit;
  assign swa    = k_r[LIST_AW-1:0];
  assign swd    = v_r;

  always_comb begin
    case (cidx)
      REG_BM0, REG_BM1, REG_BM2, REG_BM3: prdata = bm_r[cidx[1:0]];
      REG_LIMIT: prdata = {{(CFG_DW-CNT_W){1'b0}}, lim_r};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bm_r   <= '0;
      lim_r  <= BLOCK_MAX;
      reb_r  <= 1'b0;
      v_r    <= '0;
      k_r    <= '0;
      used_r <= '0;
    end else if (cwr && cidx inside {REG_BM0, REG_BM1, REG_BM2, REG_BM3}) begin
      bm_r[cidx[1:0]] <= pwdata;
      reb_r <= 1'b1;
      v_r   <= '0;
      k_r   <= '0;
    end else begin
      if (cwr && cidx == REG_LIMIT) begin
        lim_r <= pwdata[CNT_W-1:0];
      end
      if (reb_r) begin
        k_r <= k_r + USED_W'(bm_bit);
        v_r <= v_r + 1'b1;
        if (v_r == '1) begin
          reb_r  <= 1'b0;
          used_r <= k_r + USED_W'(bm_bit);
        end
      end
    end
  end

  assign fv = vld_r[fa_q] ? fq : fa_q;
  assign sv = ({1'b0, sa_q} < used_r) ? sq : '0;

  assign eob_sym  = {1'b0, used_r} + 1'b1;
  assign is_eob   = {1'b0, in_symbol} == eob_sym;
  assign is_bad   = ({1'b0, in_symbol} > eob_sym) || (used_r == '0 && !is_eob);
  assign is_dig   = (in_symbol <= SYM_W'(1)) && !is_eob;
  assign lim      = (lim_r > BLOCK_MAX) ? BLOCK_MAX : lim_r;
  assign run_tot  = (SUM_W+1)'(bytes_r) + (SUM_W+1)'(rsum_r);
  assign ovf_run  = run_tot > (SUM_W+1)'(lim);
  assign ovf_byte = ({1'b0, bytes_r} + 1'b1) > {1'b0, lim};
  assign dig_val  = (in_symbol[0] ? SUM_W'(2) : SUM_W'(1)) << rpos_r;
  assign in_ready = (st_r == ST_IDLE) && !reb_r;
  assign acc      = in_valid & in_ready;
  assign out_free = !ov_r || out_ready;

  always_comb begin
    st_nxt    = st_r;
    p_nxt     = p_r;
    eob_nxt   = eob_r;
    ek_nxt    = ek_r;
    e_nxt     = e_r;
    byte_nxt  = byte_r;
    j_nxt     = j_r;
    ract_nxt  = ract_r;
    rsum_nxt  = rsum_r;
    rpos_nxt  = rpos_r;
    bytes_nxt = bytes_r;
    clr       = 1'b0;
    fre = 1'b0; fra = '0; fwe = 1'b0; fwa = '0; fwd = '0;
    sre = 1'b0; sra = '0;
    ld = 1'b0; ld_kind = KIND_DATA; ld_val = '0; ld_cnt = '0; ld_last = 1'b1;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          if (is_bad) begin
            ek_nxt = KIND_BAD;
            st_nxt = ST_ERR;
          end else if (is_dig) begin
            if (rpos_r >= POS_W'(MAX_RUN_DIGITS)) begin
              ek_nxt = KIND_LONG;
              st_nxt = ST_ERR;
            end else begin
              rsum_nxt = rsum_r + dig_val;
              rpos_nxt = rpos_r + 1'b1;
              ract_nxt = 1'b1;
            end
          end else begin
            p_nxt   = LIST_AW'(in_symbol - 1'b1);
            eob_nxt = is_eob;
            if (ract_r) begin
              if (ovf_run) begin
                ek_nxt = KIND_OVF;
                st_nxt = ST_ERR;
              end else begin
                fre    = 1'b1;
                fra    = '0;
                st_nxt = ST_RUN_RD;
              end
            end else begin
              st_nxt = ST_NEXT;
            end
          end
        end
      end
      ST_RUN_RD: begin
        sre    = 1'b1;
        sra    = fv;
        st_nxt = ST_RUN_SL;
      end
      ST_RUN_SL: begin
        byte_nxt = sv;
        st_nxt   = ST_RUN_EM;
      end
      ST_RUN_EM: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_val    = byte_r;
          ld_cnt    = rsum_r[CNT_W-1:0];
          ld_last   = 1'b0;
          bytes_nxt = run_tot[CNT_W-1:0];
          ract_nxt  = 1'b0;
          rsum_nxt  = '0;
          rpos_nxt  = '0;
          st_nxt    = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (eob_r) begin
          if (out_free) begin
            ld      = 1'b1;
            ld_kind = KIND_EOB;
            ld_cnt  = bytes_r;
            clr     = 1'b1;
            st_nxt  = ST_IDLE;
          end
        end else if (ovf_byte) begin
          ek_nxt = KIND_OVF;
          st_nxt = ST_ERR;
        end else begin
          fre    = 1'b1;
          fra    = p_r;
          st_nxt = ST_REG_RD;
        end
      end
      ST_REG_RD: begin
        e_nxt  = fv;
        sre    = 1'b1;
        sra    = fv;
        st_nxt = ST_REG_SL;
      end
      ST_REG_SL: begin
        byte_nxt = sv;
        fre      = 1'b1;
        fra      = p_r - 1'b1;
        j_nxt    = p_r - 1'b1;
        st_nxt   = ST_SHIFT;
      end
      ST_SHIFT: begin
        fwe = 1'b1;
        fwa = j_r + 1'b1;
        fwd = fv;
        if (j_r == '0) begin
          st_nxt = ST_FRONT;
        end else begin
          fre   = 1'b1;
          fra   = j_r - 1'b1;
          j_nxt = j_r - 1'b1;
        end
      end
      ST_FRONT: begin
        fwe = 1'b1;
        fwa = '0;
        fwd = e_r;
        if (out_free) begin
          ld        = 1'b1;
          ld_val    = byte_r;
          ld_cnt    = CNT_W'(1);
          bytes_nxt = bytes_r + 1'b1;
          st_nxt    = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_kind = ek_r;
          clr     = 1'b1;
          st_nxt  = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    vld_nxt = vld_r;
    if (fwe) begin
      vld_nxt[fwa] = 1'b1;
    end
    if (clr) begin
      vld_nxt   = '0;
      ract_nxt  = 1'b0;
      rsum_nxt  = '0;
      rpos_nxt  = '0;
      bytes_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      ract_r  <= 1'b0;
      rsum_r  <= '0;
      rpos_r  <= '0;
      bytes_r <= '0;
      vld_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ract_r  <= ract_nxt;
      rsum_r  <= rsum_nxt;
      rpos_r  <= rpos_nxt;
      bytes_r <= bytes_nxt;
      vld_r   <= vld_nxt;
      if (ld) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    eob_r  <= eob_nxt;
    ek_r   <= ek_nxt;
    e_r    <= e_nxt;
    byte_r <= byte_nxt;
    j_r    <= j_nxt;
    if (fre) begin
      fa_q <= fra;
    end
    if (sre) begin
      sa_q <= sra;
    end
    if (ld) begin
      ok_r    <= ld_kind;
      oval_r  <= ld_val;
      ocnt_r  <= ld_cnt;
      olast_r <= ld_last;
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_value = oval_r;
  assign out_count = ocnt_r;
  assign out_last  = olast_r;

  a_reb_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cwr && (cidx == REG_BM0 || cidx == REG_BM1 || cidx == REG_BM2 || cidx == REG_BM3))
    |=> reb_r)
    else $error("slot table rebuild did not start after bitmap write");

  a_digit_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_dig && !is_bad && rpos_r < POS_W'(MAX_RUN_DIGITS)) |=> !$rose(ov_r))
    else $error("run digit produced a result");

  a_rpos_max: assert property (@(posedge clk) disable iff (!rst_n)
    rpos_r <= POS_W'(MAX_RUN_DIGITS))
    else $error("run digit count beyond limit");

  a_bytes_max: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_r <= BLOCK_MAX)
    else $error("block byte count beyond block maximum");

endmodule

`default_nettype wire

[tb/sv/bzip2_mtf_run_decoder_core_tb.sv]
// ============================================================================
// bzip2_mtf_run_decoder_core_tb
// Drives bzip2 symbols through the move-to-front / zero-run decoder under
// several bitmap and block-limit settings, predicts every result in a
// scoreboard class and checks each result field by field.
// ============================================================================
`default_nettype none

module bzip2_mtf_run_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bzmtf_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic              last;
  } mtf_result_t;

  class mtf_scoreboard;
    logic [63:0]      bitmap [4];
    int unsigned      limit;
    logic [7:0]       front [256];
    bit               run_on;
    int unsigned      run_sum;
    int unsigned      run_pos;
    int unsigned      blk_bytes;
    mtf_result_t      expected_q [$];
    int               mismatches;
    int               n_results;
    int               n_kind [5];

    function new();
      foreach (bitmap[i]) bitmap[i] = '0;
      limit = 900000;
      mismatches = 0;
      n_results = 0;
      foreach (n_kind[i]) n_kind[i] = 0;
      clear_state();
    endfunction

    function void clear_state();
      for (int i = 0; i < 256; i++) front[i] = i[7:0];
      run_on = 0;
      run_sum = 0;
      run_pos = 0;
      blk_bytes = 0;
    endfunction

    function int unsigned used_cnt();
      int unsigned n;
      n = 0;
      for (int v = 0; v < 256; v++) n += bitmap[v >> 6][v & 63];
      return n;
    endfunction

    function logic [7:0] slot_byte(logic [7:0] slot);
      int unsigned k;
      k = 0;
      for (int v = 0; v < 256; v++) begin
        if (bitmap[v >> 6][v & 63]) begin
          if (k == slot) return v[7:0];
          k++;
        end
      end
      return 8'd0;
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [7:0] value, int unsigned count);
      mtf_result_t r;
      r.kind = kind;
      r.value = value;
      r.count = count[CNT_W-1:0];
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] data);
      if (idx < REG_LIMIT) bitmap[idx] = data;
      else if (idx == REG_LIMIT) limit = data[CNT_W-1:0];
    endfunction

    function void note_symbol(logic [SYM_W-1:0] sym);
      int unsigned used, eob, lim, total, p, n0;
      logic [7:0] e;
      bit done;
      used = used_cnt();
      eob = used + 1;
      lim = (limit > 900000) ? 900000 : limit;
      n0 = expected_q.size();
      done = 0;
      if (sym > eob || (used == 0 && sym != eob)) begin
        push(KIND_BAD, 8'd0, 0);
        clear_state();
      end else if (sym <= 1 && sym != eob) begin
        if (run_pos >= MAX_RUN_DIGITS) begin
          push(KIND_LONG, 8'd0, 0);
          clear_state();
        end else begin
          run_sum += (sym + 1) << run_pos;
          run_pos++;
          run_on = 1;
        end
      end else begin
        if (run_on) begin
          total = blk_bytes + run_sum;
          if (total > lim) begin
            push(KIND_OVF, 8'd0, 0);
            clear_state();
            done = 1;
          end else begin
            push(KIND_DATA, slot_byte(front[0]), run_sum);
            blk_bytes = total;
            run_on = 0;
            run_sum = 0;
            run_pos = 0;
          end
        end
        if (!done) begin
          if (sym == eob) begin
            push(KIND_EOB, 8'd0, blk_bytes);
            clear_state();
          end else if (blk_bytes + 1 > lim) begin
            push(KIND_OVF, 8'd0, 0);
            clear_state();
          end else begin
            p = (sym - 1) & 255;
            e = front[p];
            for (int i = p; i > 0; i--) front[i] = front[i-1];
            front[0] = e;
            push(KIND_DATA, slot_byte(e), 1);
            blk_bytes++;
          end
        end
      end
      if (expected_q.size() > n0) expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(mtf_result_t got);
      mtf_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d value=%0d count=%0d last=%0d",
                                  got.kind, got.value, got.count, got.last));
        return;
      end
      want = expected_q.pop_front();
      n_results++;
      if (want.kind < 5) n_kind[want.kind]++;
      if (got.kind !== want.kind || got.value !== want.value ||
          got.count !== want.count || got.last !== want.last)
        report_mismatch($sformatf("got kind=%0d value=%0d count=%0d last=%0d, want %0d/%0d/%0d/%0d",
                                  got.kind, got.value, got.count, got.last,
                                  want.kind, want.value, want.count, want.last));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [SYM_W-1:0]    in_symbol;
  logic                out_valid;
  logic                out_ready;
  logic [KIND_W-1:0]   out_kind;
  logic [BYTE_W-1:0]   out_value;
  logic [CNT_W-1:0]    out_count;
  logic                out_last;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  mtf_scoreboard sb = new();
  bit  calm = 0;
  bit  hold_req = 0;
  int  idle_cycles = 0;
  int  n_sent = 0;

  always #5 clk = ~clk;

  bzip2_mtf_run_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_symbol (in_symbol),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_count (out_count),
    .out_last  (out_last),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready)
  );

  always @(posedge clk) begin
    mtf_result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.kind = out_kind;
        got.value = out_value;
        got.count = out_count;
        got.last = out_last;
        sb.check_result(got);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] b0, logic [63:0] b1, logic [63:0] b2,
                           logic [63:0] b3, logic [19:0] lim);
    wait_drained();
    cfg_write(REG_BM0, b0);
    cfg_write(REG_BM1, b1);
    cfg_write(REG_BM2, b2);
    cfg_write(REG_BM3, b3);
    cfg_write(REG_LIMIT, {44'd0, lim});
  endtask

  task automatic send_symbol(logic [SYM_W-1:0] sym);
    in_valid <= 1'b1;
    in_symbol <= sym;
    do @(posedge clk); while (!in_ready);
    sb.note_symbol(sym);
    n_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_run(int digits);
    for (int i = 0; i < digits; i++) send_symbol(SYM_W'($urandom_range(0, 1)));
  endtask

  // mostly well-formed blocks: runs, regular symbols, end of block; some noise
  task automatic random_symbols(int count);
    int unsigned used, pick, top;
    for (int i = 0; i < count; i++) begin
      used = sb.used_cnt();
      pick = $urandom_range(0, 99);
      if (pick < 4) send_symbol(SYM_W'($urandom()));
      else if (pick < 10 || used < 2) send_symbol(SYM_W'(used + 1));
      else if (pick < 30) send_run($urandom_range(0, 9) == 0 ? $urandom_range(19, 22)
                                                             : $urandom_range(1, 3));
      else begin
        top = (used - 1 < 7) ? used - 1 : 7;
        if ($urandom_range(0, 4) == 0) send_symbol(SYM_W'($urandom_range(2, used)));
        else send_symbol(SYM_W'(2 + $urandom_range(0, top)));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_symbol <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty bitmap: only symbol 1 (end of block) is legal
    send_symbol(9'd1);
    send_symbol(9'd0);
    send_symbol(9'd511);
    send_symbol(9'd2);

    // full bitmap: extremes, runs, end of block, run too long, bad symbols
    configure('1, '1, '1, '1, 20'd900000);
    send_symbol(9'd2);
    send_symbol(9'd256);
    send_symbol(9'd0);
    send_symbol(9'd1);
    send_symbol(9'd128);
    send_symbol(9'd257);
    send_symbol(9'd258);
    send_symbol(9'd511);
    for (int i = 0; i < 22; i++) send_symbol(9'd0);
    send_symbol(9'd3);
    send_symbol(9'd257);

    // small limit: overflow on run close and on a regular byte, then zero limit
    configure(64'h8000_0000_0000_0001, 64'h0, 64'hF0, 64'h0, 20'd3);
    send_symbol(9'd1);
    send_symbol(9'd1);
    send_symbol(9'd2);
    send_symbol(9'd2);
    send_symbol(9'd3);
    send_symbol(9'd2);
    send_symbol(9'd3);
    configure(64'h8000_0000_0000_0001, 64'h0, 64'hF0, 64'h0, 20'd0);
    send_symbol(9'd2);
    send_symbol(9'd0);
    send_symbol(9'd4);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure('1, '1, '1, '1, 20'hFFFFF);
        1: configure({$urandom, $urandom} & {$urandom, $urandom}, {$urandom, $urandom},
                     64'h0, {$urandom, $urandom} & {$urandom, $urandom},
                     20'($urandom_range(1, 60)));
        2: configure(64'h0, 64'h0, 64'h0, 64'h8000_0000_0000_0000,
                     20'($urandom_range(0, 4)));
        3: configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, 20'd900000);
        4: configure({$urandom, $urandom}, 64'h0, {$urandom, $urandom}, 64'h0, 20'd1);
        default: configure('1, {$urandom, $urandom}, '1, {$urandom, $urandom},
                           20'($urandom_range(20, 200)));
      endcase
      if (ph == 3) begin
        hold_req = 1;
        random_symbols(25);
        wait_drained();
      end
      if (ph == 5) calm = 1;
      random_symbols(35);
    end

    wait_drained();
    $display("sent %0d symbols, checked %0d results", n_sent, sb.n_results);
    $display("data %0d, end of block %0d, run too long %0d, overflow %0d, bad symbol %0d",
             sb.n_kind[0], sb.n_kind[1], sb.n_kind[2], sb.n_kind[3], sb.n_kind[4]);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
sv/bzmtf_pkg.sv
sv/bzmtf_ram.sv
sv/bzip2_mtf_run_decoder_core.sv
tb/sv/bzip2_mtf_run_decoder_core_tb.sv
